// File: design/nhs_pkg.sv
// Shared types and constants for the nearest hex search block.
package nhs_pkg;

	localparam int unsigned CFG_INDEX_BITS = 2;

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		REG_TARGET_X     = 2'd0,
		REG_TARGET_Y     = 2'd1,
		REG_TARGET_VALID = 2'd2
	} cfg_reg_t;

endpackage

// File: design/nhs_dist.sv
// Hex-grid distance between the target and one candidate in staggered-column coordinates.
module nhs_dist #(
	parameter int unsigned COORD_BITS = 10
) (
	input  logic [COORD_BITS-1:0] ax,
	input  logic [COORD_BITS-1:0] ay,
	input  logic [COORD_BITS-1:0] bx,
	input  logic [COORD_BITS-1:0] by,
	output logic [COORD_BITS:0]   distance
);

	logic [COORD_BITS-1:0] dx;
	logic [COORD_BITS-1:0] dy;
	logic                  pen;
	logic [COORD_BITS:0]   other;

	always_comb begin
		dx = (ax > bx) ? ax - bx : bx - ax;
		dy = (ay > by) ? ay - by : by - ay;
		pen = ((ay < by) && !ax[0] && bx[0]) || ((ay > by) && ax[0] && !bx[0]);
		other = {1'b0, dy} + {{COORD_BITS{1'b0}}, pen} + {2'b00, dx[COORD_BITS-1:1]};
		distance = ({1'b0, dx} > other) ? {1'b0, dx} : other;
	end

endmodule

// File: design/nhs_track.sv
// Running nearest-hex tracker with list position, overflow flag and result register.
module nhs_track #(
	parameter int unsigned COORD_BITS = 10,
	parameter int unsigned MAX_LIST   = 1024
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_vld,
	input  logic                        item_last,
	input  logic                        item_reach,
	input  logic [COORD_BITS:0]         item_dist,
	output logic                        item_take,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic                        found,
	output logic [$clog2(MAX_LIST)-1:0] closest_index,
	output logic [COORD_BITS:0]         best_distance,
	output logic                        overflow
);

	localparam int unsigned IW = $clog2(MAX_LIST);
	localparam int unsigned PW = IW + 1;
	localparam int unsigned DW = COORD_BITS + 1;

	logic          result_valid_q;
	logic          found_q;
	logic [IW-1:0] index_q;
	logic [DW-1:0] dist_q;
	logic          overflow_q;

	logic [DW-1:0] best_dist_q;
	logic [IW-1:0] best_pos_q;
	logic          have_best_q;
	logic [PW-1:0] position_q;
	logic          too_long_q;

	logic [DW-1:0] best_dist_n;
	logic [IW-1:0] best_pos_n;
	logic          have_best_n;
	logic [PW-1:0] position_n;
	logic          too_long_n;
	logic          out_free;
	logic          load_out;

	always_comb begin
		out_free = !result_valid_q || !result_stall;
		item_take = item_vld && (!item_last || out_free);
		load_out = item_take && item_last;

		best_dist_n = best_dist_q;
		best_pos_n = best_pos_q;
		have_best_n = have_best_q;
		position_n = position_q;
		too_long_n = too_long_q;
		if (position_q == PW'(MAX_LIST)) begin
			too_long_n = 1'b1;
		end else begin
			if (item_reach && (!have_best_q || item_dist < best_dist_q)) begin
				best_dist_n = item_dist;
				best_pos_n = position_q[IW-1:0];
				have_best_n = 1'b1;
			end
			position_n = position_q + PW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= '1;
			best_pos_q <= '0;
			have_best_q <= 1'b0;
			position_q <= '0;
			too_long_q <= 1'b0;
		end else if (item_take) begin
			if (item_last) begin
				best_dist_q <= '1;
				best_pos_q <= '0;
				have_best_q <= 1'b0;
				position_q <= '0;
				too_long_q <= 1'b0;
			end else begin
				best_dist_q <= best_dist_n;
				best_pos_q <= best_pos_n;
				have_best_q <= have_best_n;
				position_q <= position_n;
				too_long_q <= too_long_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (load_out) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			found_q <= have_best_n;
			index_q <= have_best_n ? best_pos_n : '0;
			dist_q <= have_best_n ? best_dist_n : '0;
			overflow_q <= too_long_n;
		end
	end

	assign result_valid = result_valid_q;
	assign found = found_q;
	assign closest_index = index_q;
	assign best_distance = dist_q;
	assign overflow = overflow_q;

endmodule

// File: design/nearest_hex_search.sv
// Top level of the nearest hex search: configuration, input register and tracker.
//
// Channel   Direction  Handshake                  Payload
// item      in         item_valid / item_stall    hex_x, hex_y, hex_valid, last
// result    out        result_valid / result_stall found, closest_index, best_distance, overflow
// config    in         cfg_wr_en                  cfg_index, cfg_data
//
// One item is taken every cycle unless stalled; the last item of a list raises result_valid.
// The rate is set by the single tracker update that follows the input register.
// Reset clears the running search and sets the target to column 0, row 0, valid.
// Only a last item waits on a stalled result; other items keep flowing while a result is held.
module nearest_hex_search #(
	parameter int unsigned MAX_LIST   = 1024,
	parameter int unsigned COORD_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [nhs_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [COORD_BITS-1:0]               cfg_data,
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic [COORD_BITS-1:0]               hex_x,
	input  logic [COORD_BITS-1:0]               hex_y,
	input  logic                                hex_valid,
	input  logic                                last,
	output logic                                result_valid,
	input  logic                                result_stall,
	output logic                                found,
	output logic [$clog2(MAX_LIST)-1:0]         closest_index,
	output logic [COORD_BITS:0]                 best_distance,
	output logic                                overflow
);

	logic [COORD_BITS-1:0] target_x_q;
	logic [COORD_BITS-1:0] target_y_q;
	logic                  target_valid_q;

	logic                  valid_s1;
	logic [COORD_BITS-1:0] hex_x_s1;
	logic [COORD_BITS-1:0] hex_y_s1;
	logic                  hex_valid_s1;
	logic                  last_s1;

	logic                  take_s1;
	logic [COORD_BITS:0]   dist_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			target_x_q <= '0;
			target_y_q <= '0;
			target_valid_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (nhs_pkg::cfg_reg_t'(cfg_index))
				nhs_pkg::REG_TARGET_X: begin
					target_x_q <= cfg_data;
				end
				nhs_pkg::REG_TARGET_Y: begin
					target_y_q <= cfg_data;
				end
				nhs_pkg::REG_TARGET_VALID: begin
					target_valid_q <= cfg_data[0];
				end
				default: begin
				end
			endcase
		end
	end

	assign item_stall = valid_s1 && !take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			hex_x_s1 <= hex_x;
			hex_y_s1 <= hex_y;
			hex_valid_s1 <= hex_valid;
			last_s1 <= last;
		end
	end

	nhs_dist #(
		.COORD_BITS(COORD_BITS)
	) u_dist (
		.ax      (target_x_q),
		.ay      (target_y_q),
		.bx      (hex_x_s1),
		.by      (hex_y_s1),
		.distance(dist_s1)
	);

	nhs_track #(
		.COORD_BITS(COORD_BITS),
		.MAX_LIST  (MAX_LIST)
	) u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_vld     (valid_s1),
		.item_last    (last_s1),
		.item_reach   (hex_valid_s1 && target_valid_q),
		.item_dist    (dist_s1),
		.item_take    (take_s1),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.found        (found),
		.closest_index(closest_index),
		.best_distance(best_distance),
		.overflow     (overflow)
	);

endmodule
